@@ hw/rtl/lbpucs_pkg.sv @@
package lbpucs_pkg;

    localparam int MAX_WIDTH_DEF         = 256;
    localparam int MAX_HEIGHT_DEF        = 256;
    localparam int MAX_REGION_RADIUS_DEF = 8;

    localparam int NUM_NB = 8;
    localparam int SMP_W  = 16;
    localparam int THR_W  = 16;
    localparam int RAD_W  = 4;
    localparam int POS_W  = 9;
    localparam int CODE_W = 4;
    localparam int CNT_W  = 9;

    localparam logic [CODE_W-1:0] NONUNIFORM_CODE = 4'd9;
    localparam logic [CODE_W-1:0] SHARP_CODE_MIN  = 4'd6;

    // configuration register indexes
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_RADIUS    = 1'b1;

    // input word function
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // walker status towards the top level
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] area;
    } t_walk_res;

endpackage

@@ hw/rtl/lbpucs_ram.sv @@
module lbpucs_ram
    import lbpucs_pkg::*;
#(
    parameter int WIDTH = CODE_W,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/lbpucs_code.sv @@
module lbpucs_code
    import lbpucs_pkg::*;
(
    input  logic [SMP_W-1:0]             i_center,
    input  logic [NUM_NB-1:0][SMP_W-1:0] i_nb,
    input  logic [THR_W-1:0]             i_threshold,
    output logic [CODE_W-1:0]            o_code
);

    logic [NUM_NB-1:0] w_bits;
    logic [NUM_NB-1:0] w_edges;
    logic [CODE_W-1:0] w_ones;
    logic [CODE_W-1:0] w_trans;

    always_comb begin
        logic [SMP_W-1:0] d;
        w_ones  = '0;
        w_trans = '0;
        for (int k = 0; k < NUM_NB; k++) begin
            d = (i_nb[k] >= i_center) ? (i_nb[k] - i_center) : (i_center - i_nb[k]);
            w_bits[k] = (d >= i_threshold);
        end
        // neighbour k against k+1, wrapping round the circle
        w_edges = w_bits ^ {w_bits[0], w_bits[NUM_NB-1:1]};
        for (int k = 0; k < NUM_NB; k++) begin
            w_ones  = w_ones + CODE_W'(w_bits[k]);
            w_trans = w_trans + CODE_W'(w_edges[k]);
        end
        o_code = (w_trans <= CODE_W'(2)) ? w_ones : NONUNIFORM_CODE;
    end

endmodule

@@ hw/rtl/lbpucs_walk.sv @@
module lbpucs_walk
    import lbpucs_pkg::*;
#(
    parameter int MAX_WIDTH         = MAX_WIDTH_DEF,
    parameter int MAX_REGION_RADIUS = MAX_REGION_RADIUS_DEF,
    parameter int RW                = $clog2(MAX_REGION_RADIUS + 1),
    parameter int AW                = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [POS_W-1:0] i_row,
    input  logic [POS_W-1:0] i_col,
    input  logic [RW-1:0]    i_radius,
    output logic             o_re,
    output logic [AW-1:0]    o_raddr,
    input  logic [CODE_W-1:0] i_rdata,
    output t_walk_res        o_res
);

    localparam int STORE_COLS = MAX_WIDTH + 2 * MAX_REGION_RADIUS;
    localparam int PW         = $clog2((1 << POS_W) + MAX_REGION_RADIUS);
    localparam int SQW        = 2 * RW + 1;

    localparam logic [1:0] W_IDLE  = 2'd0;
    localparam logic [1:0] W_RUN   = 2'd1;
    localparam logic [1:0] W_DRAIN = 2'd2;

    logic [1:0]       r_state;
    logic [PW-1:0]    r_x;
    logic [PW-1:0]    r_y;
    logic [RW-1:0]    r_r;
    logic [RW-1:0]    r_i;
    logic [RW-1:0]    r_j;
    logic [1:0]       r_q;
    logic             r_pend;
    logic             r_done;
    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_area;

    logic [PW-1:0]  w_rsel;
    logic [PW-1:0]  w_csel;
    logic [RW-1:0]  w_j1;
    logic [SQW-1:0] w_dist;
    logic [SQW-1:0] w_lim;
    logic           w_j_ok;
    logic           w_i_last;

    // quadrant: bit 1 mirrors the row offset, bit 0 the column offset
    assign w_rsel = r_q[1] ? (r_x - PW'(r_i)) : (r_x + PW'(r_i));
    assign w_csel = r_q[0] ? (r_y - PW'(r_j)) : (r_y + PW'(r_j));

    assign w_j1     = r_j + RW'(1);
    assign w_dist   = SQW'(r_i) * SQW'(r_i) + SQW'(w_j1) * SQW'(w_j1);
    assign w_lim    = SQW'(r_r) * SQW'(r_r);
    assign w_j_ok   = (w_dist < w_lim);
    assign w_i_last = (SQW'(r_i) + SQW'(1) >= SQW'(r_r));

    assign o_re    = (r_state == W_RUN);
    assign o_raddr = AW'(32'(w_rsel) * 32'(STORE_COLS) + 32'(w_csel));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_pend <= o_re;
            r_done <= 1'b0;
            case (r_state)
                W_IDLE: begin
                    if (i_start) begin
                        r_state <= (i_radius == '0) ? W_DRAIN : W_RUN;
                    end
                end
                W_RUN: begin
                    if (r_q == 2'd3 && !w_j_ok && w_i_last) begin
                        r_state <= W_DRAIN;
                    end
                end
                W_DRAIN: begin
                    r_done  <= 1'b1;
                    r_state <= W_IDLE;
                end
                default: begin
                    r_state <= W_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == W_IDLE && i_start) begin
            r_x    <= PW'(i_row) + PW'(i_radius);
            r_y    <= PW'(i_col) + PW'(i_radius);
            r_r    <= i_radius;
            r_i    <= '0;
            r_j    <= '0;
            r_q    <= '0;
            r_hits <= '0;
            r_area <= '0;
        end else begin
            if (r_pend && i_rdata >= SHARP_CODE_MIN) begin
                r_hits <= r_hits + CNT_W'(1);
            end
            if (r_state == W_RUN) begin
                r_q <= r_q + 2'd1;
                if (r_q == 2'd0) begin
                    r_area <= r_area + CNT_W'(4);
                end
                if (r_q == 2'd3) begin
                    if (w_j_ok) begin
                        r_j <= w_j1;
                    end else begin
                        r_i <= r_i + RW'(1);
                        r_j <= '0;
                    end
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.hits = r_hits;
    assign o_res.area = r_area;

endmodule

@@ hw/rtl/lbp_uniform_code_sharpness.sv @@
// Channel  Dir  Handshake                Payload
// s        in   i_s_tvalid / o_s_tready  tdata row, col, centre, neighbours 0..7; tuser func
// m        out  o_m_tvalid / i_m_tready  tdata lbp_code, hit_count, disc_area, bad_position
// cfg      in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A load passes through accept, code + store write, and hand-off to the output register.
// A query reads the store once per disc offset and quadrant on the single store read port;
// at radius 8 the disc has 56 offsets. A bad query goes from accept straight to the hold state.
// Synchronous active-low reset clears control only; the code store is not cleared.
// One word in flight; the next word is taken while a finished result waits on m.
module lbp_uniform_code_sharpness
    import lbpucs_pkg::*;
#(
    parameter int MAX_WIDTH         = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT        = MAX_HEIGHT_DEF,
    parameter int MAX_REGION_RADIUS = MAX_REGION_RADIUS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [8:0] row, [17:9] col, [33:18] centre, [49:34]..[161:146] neighbour 0..7, rest zero
    input  logic [167:0] i_s_tdata,
    // [0] func
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [3:0] lbp_code, [12:4] hit_count, [21:13] disc_area, [22] bad_position, [23] zero
    output logic [23:0]  o_m_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    localparam int STORE_COLS = MAX_WIDTH + 2 * MAX_REGION_RADIUS;
    localparam int STORE_ROWS = MAX_HEIGHT + 2 * MAX_REGION_RADIUS;
    localparam int DEPTH      = STORE_ROWS * STORE_COLS;
    localparam int AW         = $clog2(DEPTH);
    localparam int RW         = $clog2(MAX_REGION_RADIUS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [THR_W-1:0]          r_threshold;
    logic [RAD_W-1:0]          r_radius;
    logic [POS_W-1:0]          r_row;
    logic [POS_W-1:0]          r_col;
    logic [SMP_W-1:0]          r_center;
    logic [NUM_NB-1:0][SMP_W-1:0] r_nb;
    logic [CODE_W-1:0]         r_res_code;
    logic [CNT_W-1:0]          r_res_hits;
    logic [CNT_W-1:0]          r_res_area;
    logic                      r_res_bad;
    logic                      r_out_valid;
    logic [23:0]               r_out_data;

    logic                      w_accept;
    logic [POS_W-1:0]          w_in_row;
    logic [POS_W-1:0]          w_in_col;
    logic                      w_q_bad;
    logic [RW-1:0]             w_eff_r;
    logic                      w_load_ok;
    logic [CODE_W-1:0]         w_code;
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic                      w_start;
    logic                      w_re;
    logic [AW-1:0]             w_raddr;
    logic [CODE_W-1:0]         w_rdata;
    logic                      w_out_free;
    t_walk_res                 w_walk;

    assign w_in_row = i_s_tdata[8:0];
    assign w_in_col = i_s_tdata[17:9];

    assign o_s_tready  = (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign w_eff_r = (32'(r_radius) > 32'(MAX_REGION_RADIUS)) ?
                     RW'(MAX_REGION_RADIUS) : RW'(r_radius);

    assign w_q_bad   = (32'(w_in_row) >= 32'(MAX_HEIGHT)) || (32'(w_in_col) >= 32'(MAX_WIDTH));
    assign w_load_ok = (32'(r_row) < 32'(MAX_HEIGHT) + 2 * 32'(w_eff_r)) &&
                       (32'(r_col) < 32'(MAX_WIDTH) + 2 * 32'(w_eff_r));
    assign w_start   = w_accept && (i_s_tuser != FUNC_LOAD) && !w_q_bad;

    assign w_we    = (r_state == S_LOAD) && w_load_ok;
    assign w_waddr = AW'(32'(r_row) * 32'(STORE_COLS) + 32'(r_col));

    assign w_out_free = !r_out_valid || i_m_tready;

    lbpucs_code u_code (
        .i_center    (r_center),
        .i_nb        (r_nb),
        .i_threshold (r_threshold),
        .o_code      (w_code)
    );

    lbpucs_walk #(
        .MAX_WIDTH         (MAX_WIDTH),
        .MAX_REGION_RADIUS (MAX_REGION_RADIUS),
        .RW                (RW),
        .AW                (AW)
    ) u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_row    (w_in_row),
        .i_col    (w_in_col),
        .i_radius (w_eff_r),
        .o_re     (w_re),
        .o_raddr  (w_raddr),
        .i_rdata  (w_rdata),
        .o_res    (w_walk)
    );

    lbpucs_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_code),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser == FUNC_LOAD) begin
                        n_state = S_LOAD;
                    end else if (w_q_bad) begin
                        n_state = S_HOLD;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_LOAD: n_state = S_HOLD;
            S_WALK: begin
                if (w_walk.done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_threshold <= '0;
            r_radius    <= RAD_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_THRESHOLD: r_threshold <= i_cfg_data;
                    REG_RADIUS:    r_radius    <= i_cfg_data[RAD_W-1:0];
                    default:       r_threshold <= r_threshold;
                endcase
            end
            if (r_state == S_HOLD && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row    <= w_in_row;
            r_col    <= w_in_col;
            r_center <= i_s_tdata[33:18];
            for (int k = 0; k < NUM_NB; k++) begin
                r_nb[k] <= i_s_tdata[34 + k * SMP_W +: SMP_W];
            end
            // a query off the image leaves straight for the hold state
            r_res_code <= '0;
            r_res_hits <= '0;
            r_res_area <= '0;
            r_res_bad  <= (i_s_tuser != FUNC_LOAD) && w_q_bad;
        end else if (r_state == S_LOAD) begin
            r_res_code <= w_code;
            r_res_bad  <= !w_load_ok;
        end else if (r_state == S_WALK && w_walk.done) begin
            r_res_hits <= w_walk.hits;
            r_res_area <= w_walk.area;
        end
        if (r_state == S_HOLD && w_out_free) begin
            r_out_data <= {1'b0, r_res_bad, r_res_area, r_res_hits, r_res_code};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTH
    a_write_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_LOAD))
        else $error("store written outside load step");

    a_walk_done_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_walk.done |-> (r_state == S_WALK))
        else $error("walker finished with no query in progress");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted word did not start work");

    a_reads_only_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_re |-> (r_state == S_WALK))
        else $error("store read outside a query");

    a_bad_query_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && r_res_bad) |-> (r_res_hits == '0 && r_res_area == '0))
        else $error("bad position result carries counts");
`endif

endmodule
